>>> hdl/tkbsd_pkg.sv
// tkbsd_pkg: sizes, request codes and the seed mask of the block-shuffle decryptor.
// No dependencies; imported by the input channel interface and the top level.
package tkbsd_pkg;

  // BLOCK_BYTES must be a power of two, 8..256.
  localparam int BLOCK_BYTES = 64;
  localparam int KEY_ENTRIES = 256;
  localparam int BLK_W       = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = BLK_W + 1;
  localparam int KEY_W       = $clog2(KEY_ENTRIES);

  localparam logic [31:0] SEED_MASK = 32'hCAFE_BABE;

  typedef logic [1:0] req_t;
  localparam req_t REQ_KEY    = 2'd0;
  localparam req_t REQ_SWAP   = 2'd1;
  localparam req_t REQ_START  = 2'd2;
  localparam req_t REQ_CIPHER = 2'd3;

endpackage

>>> hdl/tkbsd_in_if.sv
// tkbsd_in_if: input channel (request words) of the block-shuffle decryptor.
// Depends on tkbsd_pkg.
interface tkbsd_in_if
  import tkbsd_pkg::*;
  ();
  logic        valid;
  logic        ready;
  req_t        req_type;
  logic [7:0]  table_index;
  logic [31:0] table_word;
  logic [31:0] file_crc;
  logic [7:0]  cipher_byte;
  logic        byte_is_final;

  modport source (output valid, req_type, table_index, table_word, file_crc,
                  cipher_byte, byte_is_final, input ready);
  modport sink   (input valid, req_type, table_index, table_word, file_crc,
                  cipher_byte, byte_is_final, output ready);
endinterface

>>> hdl/tkbsd_out_if.sv
// tkbsd_out_if: result channel (plain byte words) of the block-shuffle decryptor.
// No dependencies.
interface tkbsd_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       run_last;
  logic       file_done;

  modport source (output valid, plain_byte, run_last, file_done, input ready);
  modport sink   (input valid, plain_byte, run_last, file_done, output ready);
endinterface

>>> hdl/tkbsd_ram.sv
// tkbsd_ram: generic simple dual-port RAM, one write and one registered read port.
// Read data updates only when re is high. No dependencies.
module tkbsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hdl/table_keyed_block_shuffle_decrypt.sv
// table_keyed_block_shuffle_decrypt: table-keyed decryptor with block shuffle on output.
// Depends on tkbsd_pkg, tkbsd_in_if, tkbsd_out_if and tkbsd_ram.
// Timing: load and start words are taken in IDLE; a cipher byte is accepted (key RAM read),
// then folded into the seed in UPD. A byte that closes a block then holds the input off while
// the block drains through swap read, store read and output register, then one byte per
// cycle while out_ch.ready holds.
// Reset (rst_n low, synchronous): seed, fill count, shift and control clear; valid bits for
// the key and swap tables clear at once (unwritten entries read as zero / identity).
module table_keyed_block_shuffle_decrypt
  import tkbsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  tkbsd_in_if.sink    in_ch,
  tkbsd_out_if.source out_ch
);

  // Sequencer: IDLE takes words, UPD folds the key word into the seed,
  // EMIT runs the readout pipeline for one block.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [KEY_ENTRIES-1:0] kvalid_r, kvalid_nxt;
  logic [BLOCK_BYTES-1:0] swv_r, swv_nxt;
  logic [31:0]            seed_r, seed_nxt;
  logic [BLK_W-1:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CNT_W-1:0]       i_r, i_nxt;
  logic                   s1_v_r, s1_v_nxt;
  logic                   s2_v_r, s2_v_nxt;
  logic                   out_v_r, out_v_nxt;

  // Payload registers, no reset.
  logic                   kv_q_r;
  logic                   fin_q_r;
  logic [CNT_W-1:0]       emit_n_r;
  logic                   perm_r;
  logic [CNT_W-1:0]       idx1_r;
  logic                   sv_q_r;
  logic [CNT_W-1:0]       idx2_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic                   out_done_r;

  logic                   accept;
  logic                   is_cipher;
  logic                   advance;
  logic                   issue;
  logic                   emit_start;
  logic                   emit_perm;
  logic [CNT_W-1:0]       emit_n;
  logic [CNT_W-1:0]       fill_inc;
  logic                   stage2_last;

  logic                   key_we;
  logic [31:0]            key_rdata;
  logic                   swap_we;
  logic                   swap_re;
  logic [BLK_W-1:0]       swap_rdata;
  logic [BLK_W-1:0]       swap_val;
  logic                   store_we;
  logic [BLK_W-1:0]       store_raddr;
  logic [7:0]             store_rdata;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_cipher   = accept && (in_ch.req_type == REQ_CIPHER);

  assign key_we   = accept && (in_ch.req_type == REQ_KEY);
  // Swap loads beyond the table are dropped.
  assign swap_we  = accept && (in_ch.req_type == REQ_SWAP) &&
                    ({1'b0, in_ch.table_index} < (KEY_W + 1)'(BLOCK_BYTES));
  assign store_we = is_cipher;

  // Readout pipeline moves when the output register is free or being drained.
  assign advance  = (state_r == ST_EMIT) && (!out_v_r || out_ch.ready);
  assign issue    = advance && (i_r != emit_n_r);
  assign swap_re  = advance;

  // Stage 1 -> store address: permuted blocks go through swap table plus shift.
  assign swap_val    = sv_q_r ? swap_rdata : idx1_r[BLK_W-1:0];
  assign store_raddr = perm_r ? (swap_val + shift_r) : idx1_r[BLK_W-1:0];
  assign stage2_last = ((idx2_r + CNT_W'(1)) == emit_n_r);

  assign fill_inc = fill_r + CNT_W'(1);

  tkbsd_ram #(.WIDTH(32), .DEPTH(KEY_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_ch.table_index),
    .wdata (in_ch.table_word),
    .re    (is_cipher),
    .raddr (in_ch.cipher_byte),
    .rdata (key_rdata)
  );

  tkbsd_ram #(.WIDTH(BLK_W), .DEPTH(BLOCK_BYTES)) u_swap_ram (
    .clk   (clk),
    .we    (swap_we),
    .waddr (in_ch.table_index[BLK_W-1:0]),
    .wdata (in_ch.table_word[BLK_W-1:0]),
    .re    (swap_re),
    .raddr (i_r[BLK_W-1:0]),
    .rdata (swap_rdata)
  );

  tkbsd_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill_r[BLK_W-1:0]),
    .wdata (seed_r[7:0] ^ in_ch.cipher_byte),
    .re    (advance),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    kvalid_nxt = kvalid_r;
    swv_nxt    = swv_r;
    seed_nxt   = seed_r;
    shift_nxt  = shift_r;
    fill_nxt   = fill_r;
    i_nxt      = i_r;
    s1_v_nxt   = s1_v_r;
    s2_v_nxt   = s2_v_r;
    out_v_nxt  = out_v_r;
    emit_start = 1'b0;
    emit_perm  = 1'b0;
    emit_n     = fill_inc;

    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.req_type)
            REQ_KEY:    kvalid_nxt[in_ch.table_index] = 1'b1;
            REQ_SWAP: begin
              if (swap_we) begin
                swv_nxt[in_ch.table_index[BLK_W-1:0]] = 1'b1;
              end
            end
            REQ_START: begin
              seed_nxt = in_ch.file_crc ^ SEED_MASK;
              fill_nxt = '0;
            end
            REQ_CIPHER: begin
              // Shift is latched from the seed at the block's first byte.
              if (fill_r == '0) begin
                shift_nxt = seed_r[16 +: BLK_W];
              end
              state_nxt = ST_UPD;
            end
            default: ;
          endcase
        end
      end
      ST_UPD: begin
        seed_nxt = (kv_q_r ? key_rdata : 32'd0) ^ {8'd0, seed_r[31:8]};
        if (fill_inc == CNT_W'(BLOCK_BYTES)) begin
          emit_start = 1'b1;
          emit_perm  = 1'b1;
        end else if (fin_q_r) begin
          emit_start = 1'b1;
        end
        if (emit_start) begin
          fill_nxt  = '0;
          i_nxt     = '0;
          s1_v_nxt  = 1'b0;
          s2_v_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          fill_nxt  = fill_inc;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          out_v_nxt = s2_v_r;
          s2_v_nxt  = s1_v_r;
          s1_v_nxt  = issue;
          if (issue) begin
            i_nxt = i_r + CNT_W'(1);
          end
        end
        // Drained: last byte sits in the output register.
        if (!s1_v_r && !s2_v_r && (i_r == emit_n_r)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      kvalid_r <= '0;
      swv_r    <= '0;
      seed_r   <= '0;
      shift_r  <= '0;
      fill_r   <= '0;
      i_r      <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      kvalid_r <= kvalid_nxt;
      swv_r    <= swv_nxt;
      seed_r   <= seed_nxt;
      shift_r  <= shift_nxt;
      fill_r   <= fill_nxt;
      i_r      <= i_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_cipher) begin
      kv_q_r  <= kvalid_r[in_ch.cipher_byte];
      fin_q_r <= in_ch.byte_is_final;
    end
    if (emit_start) begin
      emit_n_r <= emit_n;
      perm_r   <= emit_perm;
    end
    if (advance) begin
      idx1_r     <= i_r;
      sv_q_r     <= swv_r[i_r[BLK_W-1:0]];
      idx2_r     <= idx1_r;
      out_byte_r <= store_rdata;
      out_last_r <= stage2_last;
      out_done_r <= stage2_last && fin_q_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.plain_byte = out_byte_r;
  assign out_ch.run_last   = out_last_r;
  assign out_ch.file_done  = out_done_r;

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for table_keyed_block_shuffle_decrypt.
// Depends on tkbsd_pkg, tkbsd_in_if, tkbsd_out_if and the RTL of the decryptor.
// A built-in decryptor model predicts every plain byte; a monitor compares what comes out.
module tb;
  import tkbsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 1000; // cycles with no word moving on either side
  localparam int unsigned DRAIN_CYCLES   = 16;   // extra cycles after the last expected byte
  localparam int unsigned RANDOM_WORDS   = 110;
  localparam int unsigned MAX_REPORTS    = 10;

  // One request word, as the input channel carries it.
  typedef struct packed {
    req_t        req;
    logic [7:0]  idx;
    logic [31:0] word;
    logic [31:0] crc;
    logic [7:0]  cb;
    logic        fin;
  } req_word_t;

  // One plain byte word, as the result channel carries it.
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       run_last;
    logic       file_done;
  } plain_word_t;

  logic clk;
  logic rst_n;

  tkbsd_in_if  in_ch ();
  tkbsd_out_if out_ch ();

  table_keyed_block_shuffle_decrypt DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Decryptor model state: tables, running seed and the block being filled.
  logic [31:0]      key_tbl     [KEY_ENTRIES];
  logic [BLK_W-1:0] swap_tbl    [BLOCK_BYTES];
  logic [7:0]       plain_store [BLOCK_BYTES];
  logic [31:0]      seed;
  logic [BLK_W-1:0] shift;
  int unsigned      fill;

  plain_word_t plain_expect_q[$];

  int unsigned fail_count     = 0;
  int unsigned plain_seen     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned in_burst_left  = 0;
  int unsigned out_stall_left = 0;
  int unsigned out_burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Advance the model by one accepted word and queue the plain bytes it releases.
  function automatic void predict_word(req_word_t w);
    logic [BLK_W-1:0] src;
    plain_word_t      r;
    int unsigned      i;
    case (w.req)
      REQ_KEY: begin
        key_tbl[w.idx] = w.word;
      end
      REQ_SWAP: begin
        // indexes past the table are dropped
        if (w.idx < BLOCK_BYTES) swap_tbl[w.idx[BLK_W-1:0]] = w.word[BLK_W-1:0];
      end
      REQ_START: begin
        // a new file throws away any partial block
        seed = w.crc ^ SEED_MASK;
        fill = 0;
      end
      default: begin
        if (fill == 0) shift = seed[16 +: BLK_W];
        plain_store[fill] = seed[7:0] ^ w.cb;
        seed = key_tbl[w.cb] ^ (seed >> 8);
        fill++;
        if (fill == BLOCK_BYTES) begin
          // full block goes out shuffled, even when it also ends the file
          for (i = 0; i < BLOCK_BYTES; i++) begin
            src          = swap_tbl[i] + shift;
            r.plain_byte = plain_store[src];
            r.run_last   = (i == BLOCK_BYTES - 1);
            r.file_done  = r.run_last && w.fin;
            plain_expect_q.push_back(r);
          end
          fill = 0;
        end else if (w.fin) begin
          // short tail block goes out in stored order
          for (i = 0; i < fill; i++) begin
            r.plain_byte = plain_store[i];
            r.run_last   = (i == fill - 1);
            r.file_done  = r.run_last;
            plain_expect_q.push_back(r);
          end
          fill = 0;
        end
      end
    endcase
  endfunction

  // Drive one request word, wait for the handshake, then feed the model.
  // valid is left high so back-to-back words need no second assignment in a step.
  task automatic send_word(req_word_t w);
    int unsigned gap;
    if (in_burst_left > 0) begin
      gap = 0;
      in_burst_left--;
    end else begin
      gap = pick_gap();
      in_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : 0;
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= w.req;
    in_ch.table_index   <= w.idx;
    in_ch.table_word    <= w.word;
    in_ch.file_crc      <= w.crc;
    in_ch.cipher_byte   <= w.cb;
    in_ch.byte_is_final <= w.fin;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(w);
  endtask

  // Word builders: fields a request type ignores are filled with noise.
  task automatic load_key(logic [7:0] idx, logic [31:0] word);
    send_word('{REQ_KEY, idx, word, $urandom(), 8'($urandom()), 1'($urandom())});
  endtask

  task automatic load_swap(logic [7:0] idx, logic [31:0] word);
    send_word('{REQ_SWAP, idx, word, $urandom(), 8'($urandom()), 1'($urandom())});
  endtask

  task automatic start_file(logic [31:0] crc);
    send_word('{REQ_START, 8'($urandom()), $urandom(), crc, 8'($urandom()),
                1'($urandom())});
  endtask

  task automatic cipher(logic [7:0] cb, logic fin);
    send_word('{REQ_CIPHER, 8'($urandom()), $urandom(), $urandom(), cb, fin});
  endtask

  // Table loads at the index extremes, including swap indexes past the table.
  task automatic test_table_loads();
    load_key(8'd0, 32'hFFFF_FFFF);
    load_key(8'd255, 32'h0000_0000);
    load_key(8'hA5, $urandom());
    load_key(8'h5A, $urandom());
    load_swap(8'd0, 32'hFFFF_FFFF);   // only the low bits land: entry 0 -> 63
    load_swap(8'd63, 32'hFFFF_FFC0);  // entry 63 -> 0
    load_swap(8'd64, $urandom());     // dropped
    load_swap(8'd255, $urandom());    // dropped
  endtask

  // Short files: tail blocks of one and three bytes, byte extremes.
  task automatic test_short_files();
    start_file(32'h0000_0000);
    cipher(8'h00, 1'b0);
    cipher(8'hFF, 1'b0);
    cipher(8'hA5, 1'b1);
    start_file(32'hFFFF_FFFF);
    cipher(8'hFF, 1'b1);
  endtask

  // A start in the middle of a block drops the partial block silently.
  task automatic test_restart_mid_block();
    start_file($urandom());
    cipher(8'($urandom()), 1'b0);
    cipher(8'($urandom()), 1'b0);
    cipher(8'($urandom()), 1'b0);
    start_file($urandom());
    cipher(8'($urandom()), 1'b0);
    cipher(8'($urandom()), 1'b1);
  endtask

  // Final mark on the byte that fills a block: shuffled block with file_done at its end.
  task automatic test_final_fills_block();
    int unsigned k;
    start_file($urandom());
    for (k = 0; k < BLOCK_BYTES; k++) cipher(8'($urandom()), k == BLOCK_BYTES - 1);
  endtask

  // Bytes after a final byte, with no new start, keep the running seed.
  task automatic test_bytes_after_final();
    cipher(8'($urandom()), 1'b0);
    cipher(8'($urandom()), 1'b1);
  endtask

  // Mostly well-formed files with random content and table reloads between them;
  // some files skip the start, some never get a final mark.
  task automatic test_random_files();
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    int unsigned r;
    logic        broken;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0)
            load_key(8'($urandom()), $urandom());
          else if ($urandom_range(0, 3) == 0)
            load_swap(8'($urandom()), $urandom());
          else
            load_swap(8'($urandom_range(0, BLOCK_BYTES - 1)), $urandom());
          sent++;
        end
      end
      if ($urandom_range(0, 7) != 0) begin
        start_file($urandom());
        sent++;
      end
      r = $urandom_range(0, 9);
      if (r == 0)      len = BLOCK_BYTES;
      else if (r == 1) len = $urandom_range(BLOCK_BYTES - 1, 2 * BLOCK_BYTES + 1);
      else             len = $urandom_range(1, 12);
      broken = ($urandom_range(0, 9) == 0);
      for (k = 0; k < len; k++) cipher(8'($urandom()), (k == len - 1) && !broken);
      sent += len;
    end
  endtask

  // Result side: ready with random stalls, plus runs where it never drops.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall_left > 0) begin
      out_stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_burst_left > 0) begin
        out_burst_left--;
      end else begin
        out_stall_left = pick_gap();
        out_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : 0;
      end
    end
  end

  // Monitor: each plain byte word against the oldest expectation, field by field.
  always @(posedge clk) begin
    plain_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (plain_expect_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("unexpected plain byte %02h (last %b done %b) at %0t",
                   out_ch.plain_byte, out_ch.run_last, out_ch.file_done, $realtime);
        fail_count++;
      end else begin
        exp_w = plain_expect_q.pop_front();
        if (out_ch.plain_byte !== exp_w.plain_byte || out_ch.run_last !== exp_w.run_last ||
            out_ch.file_done !== exp_w.file_done) begin
          if (fail_count < MAX_REPORTS)
            $display("byte %0d: expected %02h last %b done %b, got %02h last %b done %b",
                     plain_seen, exp_w.plain_byte, exp_w.run_last, exp_w.file_done,
                     out_ch.plain_byte, out_ch.run_last, out_ch.file_done);
          fail_count++;
        end
      end
      plain_seen++;
    end
  end

  // Watchdog: a long stretch with no word moving on either side means a hang.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // model starts from the reset tables: zero keys, identity swap
    for (int unsigned n = 0; n < KEY_ENTRIES; n++) key_tbl[n] = '0;
    for (int unsigned n = 0; n < BLOCK_BYTES; n++) begin
      swap_tbl[n]    = BLK_W'(n);
      plain_store[n] = '0;
    end
    seed  = '0;
    shift = '0;
    fill  = 0;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_KEY;
    in_ch.table_index   <= '0;
    in_ch.table_word    <= '0;
    in_ch.file_crc      <= '0;
    in_ch.cipher_byte   <= '0;
    in_ch.byte_is_final <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // cipher bytes right after reset run on the zero seed and zero keys
    cipher(8'h3C, 1'b1);
    test_table_loads();
    test_short_files();
    test_restart_mid_block();
    test_final_fills_block();
    test_bytes_after_final();
    test_random_files();

    in_ch.valid <= 1'b0;
    while (plain_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
